### rtl/core/ppcd_pkg.sv
package ppcd_pkg;

	// Parameter defaults
	localparam int PPCD_MAX_NODES     = 1024;
	localparam int PPCD_FRACTION_BITS = 16;

	// Field widths
	localparam int POS_W      = 26;
	localparam int VEL_W      = 27;
	localparam int NODE_W     = 10;
	localparam int CHARGE_W   = 24;
	localparam int ACC_W      = 48;
	localparam int VINC_W     = 17;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 2;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT         = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_INCREMENT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_CHARGE    = CFG_IDX_W'(2);

	// Register reset values
	localparam logic [NODE_W-1:0]          CELL_COUNT_RST = NODE_W'(1000);
	localparam logic signed [VINC_W-1:0]   VINC_RST       = '0;
	localparam logic [CHARGE_W-1:0]        CHARGE_RST     = CHARGE_W'(65536);

	// Item kinds
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic [NODE_W-1:0]        cell_count;
		logic signed [VINC_W-1:0] velocity_increment;
		logic [CHARGE_W-1:0]      particle_charge;
	} ppcd_cfg_t;

	// One command from front to back
	typedef struct packed {
		logic                    kind;
		logic [NODE_W-1:0]       node;
		logic [CHARGE_W-1:0]     left_charge;
		logic [CHARGE_W-1:0]     right_charge;
		logic [POS_W-1:0]        pos;
		logic signed [VEL_W-1:0] vel;
	} ppcd_entry_t;

	typedef enum logic [3:0] {
		F_IDLE,
		F_LIM,
		F_VEL,
		F_SUM,
		F_CHK,
		F_DIV,
		F_FIX,
		F_MUL,
		F_PUSH
	} ppcd_front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_LEFT,
		B_RIGHT,
		B_READ
	} ppcd_back_state_t;

endpackage

### rtl/core/ppcd_ram.sv
module ppcd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/ppcd_queue.sv
module ppcd_queue import ppcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  ppcd_entry_t push_data,
	input  logic        pop,
	output ppcd_entry_t pop_data,
	output logic        full,
	output logic        empty
);

	ppcd_entry_t        slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("command written into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("command taken from an empty queue");

endmodule

### rtl/core/ppcd_front.sv
module ppcd_front import ppcd_pkg::*; #(
	parameter int MAX_NODES     = PPCD_MAX_NODES,
	parameter int FRACTION_BITS = PPCD_FRACTION_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    kind,
	input  logic [POS_W-1:0]        particle_position,
	input  logic signed [VEL_W-1:0] particle_velocity,
	input  logic [NODE_W-1:0]       node_number,
	input  ppcd_cfg_t               cfg,
	input  logic                    clearing,
	input  logic                    q_full,
	output logic                    q_push,
	output ppcd_entry_t             q_data,
	output logic                    busy
);

	localparam int LEN_W = NODE_W + FRACTION_BITS;
	localparam int CW    = ((LEN_W > VEL_W) ? LEN_W : VEL_W) + 2;
	localparam int NUM_W = VEL_W;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam int VEL_MAX = 2 ** (VEL_W - 1) - 1;
	localparam logic signed [CW-1:0] VHI     = CW'(VEL_MAX);
	localparam logic signed [CW-1:0] VLO_ABS = CW'(VEL_MAX + 1);

	ppcd_front_state_t state_q, state_d;

	logic                    kind_q;
	logic [POS_W-1:0]        pos_in_q;
	logic signed [VEL_W-1:0] vel_in_q;
	logic [NODE_W-1:0]       node_q;
	logic [LEN_W-1:0]        length_q;
	logic signed [CW-1:0]    vsum_q;
	logic signed [CW-1:0]    hi_q;
	logic signed [CW-1:0]    lo_q;
	logic signed [VEL_W-1:0] vel_q;
	logic [NUM_W-1:0]        num_q;
	logic                    neg_q;
	logic [LEN_W-1:0]        rem_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [LEN_W-1:0]        p_q;
	logic [CHARGE_W-1:0]     right_q;

	logic                      accept;
	logic [NODE_W-1:0]         cells_c;
	logic signed [CW-1:0]      lenm1_c;
	logic signed [CW-1:0]      lo_abs_c;
	logic signed [CW-1:0]      vclamp_c;
	logic signed [CW-1:0]      s_c;
	logic signed [CW-1:0]      abs_c;
	logic [LEN_W:0]            trial_c;
	logic [LEN_W:0]            reduced_c;
	logic [CHARGE_W+FRACTION_BITS-1:0] prod_c;
	logic [POS_W+LEN_W-1:0]    pos_ext_c;

	assign busy   = (state_q != F_IDLE) || clearing;
	assign accept = start && !busy;

	// Clamp the cell count so both deposit nodes exist
	always_comb begin
		cells_c = (cfg.cell_count == '0) ? NODE_W'(1) : cfg.cell_count;
		if (int'(cells_c) > MAX_NODES - 1) begin
			cells_c = NODE_W'(MAX_NODES - 1);
		end
	end

	// Velocity limits and clamp
	assign lenm1_c  = $signed(CW'(length_q)) - $signed(CW'(1));
	assign lo_abs_c = (lenm1_c > VLO_ABS) ? VLO_ABS : lenm1_c;
	assign vclamp_c = (vsum_q > hi_q) ? hi_q : ((vsum_q < lo_q) ? lo_q : vsum_q);

	// Advanced position and its magnitude
	assign s_c   = $signed(CW'(pos_in_q)) + CW'(vel_q);
	assign abs_c = s_c[CW-1] ? -s_c : s_c;

	// One restoring step of the remainder
	assign trial_c   = {rem_q, num_q[NUM_W-1]};
	assign reduced_c = (trial_c >= {1'b0, length_q}) ? trial_c - {1'b0, length_q} : trial_c;

	// Right node share of the charge
	assign prod_c    = (CHARGE_W + FRACTION_BITS)'(cfg.particle_charge)
		* (CHARGE_W + FRACTION_BITS)'(p_q[FRACTION_BITS-1:0]);
	assign pos_ext_c = {{POS_W{1'b0}}, p_q};

	// Next state and queue write
	always_comb begin
		state_d = state_q;
		q_push  = 1'b0;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = (kind == KIND_READ) ? F_PUSH : F_LIM;
				end
			end
			F_LIM: state_d = F_VEL;
			F_VEL: state_d = F_SUM;
			F_SUM: state_d = F_CHK;
			F_CHK: begin
				state_d = (CW'(num_q) < CW'(length_q)) ? F_FIX : F_DIV;
			end
			F_DIV: begin
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					state_d = F_FIX;
				end
			end
			F_FIX: state_d = F_MUL;
			F_MUL: state_d = F_PUSH;
			F_PUSH: begin
				if (!q_full) begin
					q_push  = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	// Command contents
	always_comb begin
		q_data.kind         = kind_q;
		q_data.node         = (kind_q == KIND_READ) ? node_q : p_q[LEN_W-1:FRACTION_BITS];
		q_data.right_charge = right_q;
		q_data.left_charge  = cfg.particle_charge - right_q;
		q_data.pos          = pos_ext_c[POS_W-1:0];
		q_data.vel          = vel_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == F_CHK) begin
				cnt_q <= '0;
			end else if (state_q == F_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					kind_q   <= kind;
					pos_in_q <= particle_position;
					vel_in_q <= particle_velocity;
					node_q   <= node_number;
					length_q <= {cells_c, {FRACTION_BITS{1'b0}}};
				end
			end
			F_LIM: begin
				vsum_q <= CW'(vel_in_q) + CW'(cfg.velocity_increment);
				hi_q   <= (lenm1_c > VHI) ? VHI : lenm1_c;
				lo_q   <= -lo_abs_c;
			end
			F_VEL: vel_q <= vclamp_c[VEL_W-1:0];
			F_SUM: begin
				num_q <= abs_c[NUM_W-1:0];
				neg_q <= s_c[CW-1];
			end
			F_CHK: begin
				rem_q <= (CW'(num_q) < CW'(length_q)) ? LEN_W'(num_q) : '0;
			end
			F_DIV: begin
				rem_q <= reduced_c[LEN_W-1:0];
				num_q <= num_q << 1;
			end
			F_FIX: p_q <= (neg_q && rem_q != '0) ? length_q - rem_q : rem_q;
			F_MUL: right_q <= prod_c[CHARGE_W+FRACTION_BITS-1:FRACTION_BITS];
			default: ;
		endcase
	end

	a_rem_below_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_FIX) |-> (rem_q < length_q))
		else $error("wrapped position not below domain length");

endmodule

### rtl/core/ppcd_back.sv
module ppcd_back import ppcd_pkg::*; #(
	parameter int MAX_NODES = PPCD_MAX_NODES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  ppcd_entry_t             q_data,
	output logic                    q_pop,
	output logic                    clearing,
	output logic                    done,
	output logic [POS_W-1:0]        new_position,
	output logic signed [VEL_W-1:0] new_velocity,
	output logic [ACC_W-1:0]        node_charge
);

	localparam int AW = $clog2(MAX_NODES);

	ppcd_back_state_t state_q, state_d;

	logic                clearing_q;
	logic [AW-1:0]       clr_addr_q;
	ppcd_entry_t         entry_q;
	logic [AW-1:0]       addr_q;
	logic                in_range_q;
	logic                done_q;
	logic [POS_W-1:0]    pos_q;
	logic [VEL_W-1:0]    vel_q;
	logic [ACC_W-1:0]    charge_q;

	logic                we;
	logic [AW-1:0]       waddr;
	logic [ACC_W-1:0]    wdata;
	logic [AW-1:0]       raddr;
	logic [ACC_W-1:0]    rdata;
	logic [AW+NODE_W-1:0] node_ext_c;
	logic                in_range_c;
	logic                done_d;

	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
		input logic [CHARGE_W-1:0] b);
		logic [ACC_W:0] sum;
		sum = {1'b0, a} + (ACC_W + 1)'(b);
		return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
	endfunction

	ppcd_ram #(
		.WIDTH(ACC_W),
		.DEPTH(MAX_NODES)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign node_ext_c = {{AW{1'b0}}, q_data.node};
	assign in_range_c = int'(q_data.node) < MAX_NODES;
	assign clearing   = clearing_q;

	assign done         = done_q;
	assign new_position = pos_q;
	assign new_velocity = vel_q;
	assign node_charge  = charge_q;

	// Sequence memory accesses for the head command
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		done_d  = 1'b0;
		we      = 1'b0;
		waddr   = addr_q;
		wdata   = '0;
		raddr   = node_ext_c[AW-1:0];
		case (state_q)
			B_IDLE: begin
				if (clearing_q) begin
					we    = 1'b1;
					waddr = clr_addr_q;
				end else if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = (q_data.kind == KIND_READ) ? B_READ : B_LEFT;
				end
			end
			B_LEFT: begin
				we      = 1'b1;
				wdata   = sat_add(rdata, entry_q.left_charge);
				raddr   = addr_q + 1'b1;
				state_d = B_RIGHT;
			end
			B_RIGHT: begin
				we      = 1'b1;
				waddr   = addr_q + 1'b1;
				wdata   = sat_add(rdata, entry_q.right_charge);
				done_d  = 1'b1;
				state_d = B_IDLE;
			end
			B_READ: begin
				we      = in_range_q;
				done_d  = 1'b1;
				state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Hold control state; sweep the store clear after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(MAX_NODES - 1)) begin
					clearing_q <= 1'b0;
				end
			end
		end
	end

	// Latch the command and the result
	always_ff @(posedge clk) begin
		if (q_pop) begin
			entry_q    <= q_data;
			addr_q     <= node_ext_c[AW-1:0];
			in_range_q <= in_range_c;
		end
		if (done_d) begin
			if (entry_q.kind == KIND_READ) begin
				pos_q    <= '0;
				vel_q    <= '0;
				charge_q <= in_range_q ? rdata : '0;
			end else begin
				pos_q    <= entry_q.pos;
				vel_q    <= entry_q.vel;
				charge_q <= '0;
			end
		end
	end

	a_no_result_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |=> !done_q)
		else $error("result transfer during store clearing");
	a_right_after_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RIGHT) |-> (we && $past(we) && waddr == AW'($past(waddr) + 1'b1)))
		else $error("right node write does not follow left node write");

endmodule

### rtl/core/particle_push_charge_deposit_unit.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+------------------------------------------------
// item in   | start, busy          | kind, particle_position, particle_velocity,
//           |                      | node_number
// result    | done (one cycle)     | new_position, new_velocity, node_charge
// config    | cfg_write            | cfg_index, cfg_data
//
// In the front a read item goes straight to the queue write, which waits while the
// queue is full; a push item first passes velocity and position steps, and a divide
// step in the one-bit-per-cycle remainder unit when the advanced position lies beyond
// one domain length of the start. The back does two read-modify-writes per push and
// one read per read. After reset busy stays high while the back clears the charge
// store one entry a cycle. Results leave on done and cannot be held off; a two-entry
// command queue lets the front take the next item while the back is still working.
module particle_push_charge_deposit_unit import ppcd_pkg::*; #(
	parameter int MAX_NODES     = PPCD_MAX_NODES,
	parameter int FRACTION_BITS = PPCD_FRACTION_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    kind,
	input  logic [POS_W-1:0]        particle_position,
	input  logic signed [VEL_W-1:0] particle_velocity,
	input  logic [NODE_W-1:0]       node_number,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic                    done,
	output logic [POS_W-1:0]        new_position,
	output logic signed [VEL_W-1:0] new_velocity,
	output logic [ACC_W-1:0]        node_charge
);

	ppcd_cfg_t   cfg_q;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;
	ppcd_entry_t q_wdata;
	ppcd_entry_t q_rdata;
	logic        clearing;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_count         <= CELL_COUNT_RST;
			cfg_q.velocity_increment <= VINC_RST;
			cfg_q.particle_charge    <= CHARGE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CELL_COUNT:         cfg_q.cell_count <= cfg_data[NODE_W-1:0];
				REG_VELOCITY_INCREMENT: cfg_q.velocity_increment <= cfg_data[VINC_W-1:0];
				REG_PARTICLE_CHARGE:    cfg_q.particle_charge <= cfg_data[CHARGE_W-1:0];
				default: ;
			endcase
		end
	end

	ppcd_front #(
		.MAX_NODES    (MAX_NODES),
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.kind             (kind),
		.particle_position(particle_position),
		.particle_velocity(particle_velocity),
		.node_number      (node_number),
		.cfg              (cfg_q),
		.clearing         (clearing),
		.q_full           (q_full),
		.q_push           (q_push),
		.q_data           (q_wdata),
		.busy             (busy)
	);

	ppcd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.pop      (q_pop),
		.pop_data (q_rdata),
		.full     (q_full),
		.empty    (q_empty)
	);

	ppcd_back #(
		.MAX_NODES(MAX_NODES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.clearing    (clearing),
		.done        (done),
		.new_position(new_position),
		.new_velocity(new_velocity),
		.node_charge (node_charge)
	);

endmodule
